### rtl/sem_pkg.sv
package sem_pkg;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic [7:0] edge_value;
    logic       on_border;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // one classified pixel: neighborhood plus the results it owes
  typedef struct packed {
    logic [7:0] w0;
    logic [7:0] w1;
    logic [7:0] w2;
    logic [7:0] w3;
    logic [7:0] w4;
    logic [7:0] w5;
    logic [7:0] t;
    logic [7:0] m;
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] c;
    logic       e_mid;
    logic       mid_border;
    logic       e_right;
    logic       e_bot;
    logic       e_corner;
  } job_t;

  localparam int unsigned CfgIdxWidth = 0;
  localparam int unsigned CfgIdxHeight = 1;

endpackage

### rtl/sem_front.sv
module sem_front #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [8:0]       cfg_data,
  input  sem_pkg::in_item_t in_data,
  input  logic             in_valid,
  output logic             in_ready,
  output sem_pkg::job_t    job,
  output logic             job_valid,
  input  logic             job_ready
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [8:0] frame_width, frame_height;
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [7:0] upper_line [MAX_WIDTH];
  logic [7:0] middle_line [MAX_WIDTH];
  logic [7:0] win [6];

  // stage 1: pixel accepted, line stores being read
  logic            s1_valid;
  logic [7:0]      s1_pix;
  logic [CW-1:0]   s1_c;
  logic [RW-1:0]   s1_r;
  logic [CW:0]     s1_w;
  logic [RW:0]     s1_h;
  logic [7:0]      rd_t, rd_m;

  logic [CW:0] w_use;
  logic [RW:0] h_use;
  logic [CW:0] col_sat;
  logic [RW:0] row_sat;
  logic [CW-1:0] c_now;
  logic [RW-1:0] r_now;
  logic accept, advance;

  always_comb begin
    if (frame_width < 9'd3) w_use = (CW+1)'(3);
    else if ({23'd0, frame_width} > MAX_WIDTH) w_use = (CW+1)'(MAX_WIDTH);
    else w_use = (CW+1)'(frame_width);
    if (frame_height < 9'd3) h_use = (RW+1)'(3);
    else if ({23'd0, frame_height} > MAX_HEIGHT) h_use = (RW+1)'(MAX_HEIGHT);
    else h_use = (RW+1)'(frame_height);
    col_sat = in_data.frame_start ? '0 : {1'b0, col_pos};
    row_sat = in_data.frame_start ? '0 : {1'b0, row_pos};
    if (col_sat >= w_use) col_sat = w_use - 1'b1;
    if (row_sat >= h_use) row_sat = h_use - 1'b1;
    c_now = col_sat[CW-1:0];
    r_now = row_sat[RW-1:0];
  end

  // stage 1 forwards to the queue; only one item in flight keeps line reads coherent
  assign advance = s1_valid && (!job_valid || job_ready);
  assign in_ready = !s1_valid && (!job_valid || job_ready);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 9'd188;
      frame_height <= 9'd120;
    end else if (cfg_we) begin
      if (cfg_idx == 1'(sem_pkg::CfgIdxWidth)) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if ({1'b0, c_now} >= w_use - 1'b1) begin
          col_pos <= '0;
          row_pos <= ({1'b0, r_now} >= h_use - 1'b1) ? '0 : r_now + 1'b1;
        end else begin
          col_pos <= c_now + 1'b1;
          row_pos <= r_now;
        end
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= in_data.pixel;
      s1_c <= c_now;
      s1_r <= r_now;
      s1_w <= w_use;
      s1_h <= h_use;
      rd_t <= upper_line[c_now];
      rd_m <= middle_line[c_now];
    end
    if (advance) begin
      upper_line[s1_c] <= rd_m;
      middle_line[s1_c] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (advance) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rd_t;
      win[4] <= rd_m;
      win[5] <= s1_pix;
    end
  end

  logic rc_ok, last_c, last_r;
  sem_pkg::job_t j;
  always_comb begin
    rc_ok = (s1_r != '0) && (s1_c != '0);
    last_c = ({1'b0, s1_c} == s1_w - 1'b1);
    last_r = ({1'b0, s1_r} == s1_h - 1'b1);
    j.w0 = win[0]; j.w1 = win[1]; j.w2 = win[2];
    j.w3 = win[3]; j.w4 = win[4]; j.w5 = win[5];
    j.t = rd_t; j.m = rd_m; j.b = s1_pix;
    j.r = 8'(s1_r);
    j.c = 8'(s1_c);
    j.e_mid = rc_ok;
    j.mid_border = (s1_r == RW'(1)) || (s1_c == CW'(1));
    j.e_right = rc_ok && last_c;
    j.e_bot = last_r && (s1_c != '0);
    j.e_corner = last_r && (s1_c != '0) && last_c;
  end

  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else if (advance) job_valid <= 1'b1;
    else if (job_ready) job_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) job <= j;
  end
endmodule

### rtl/sem_back.sv
module sem_back (
  input  logic              clk,
  input  logic              rst,
  input  sem_pkg::job_t     job,
  input  logic              job_valid,
  output logic              job_ready,
  output sem_pkg::out_item_t out_data,
  output logic              out_valid,
  input  logic              out_ready
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GRAD = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_SQ   = 5'b10000
  } state_t;

  state_t state;
  sem_pkg::job_t cur;
  logic [3:0] pend;       // mid, right, bottom, corner
  logic [7:0] ax, ay;
  logic [17:0] sum;
  logic [16:0] rem;
  logic [8:0] root;
  logic [3:0] step;
  logic [7:0] mag;

  logic signed [11:0] gx, gy;
  logic [10:0] agx, agy;
  logic [18:0] trial;
  logic [17:0] rem_sh;
  logic [8:0] root_next;

  always_comb begin
    gx = $signed({4'd0, cur.t}) + $signed({3'd0, cur.m, 1'b0}) + $signed({4'd0, cur.b})
       - $signed({4'd0, cur.w0}) - $signed({3'd0, cur.w1, 1'b0}) - $signed({4'd0, cur.w2});
    gy = $signed({4'd0, cur.w0}) + $signed({3'd0, cur.w3, 1'b0}) + $signed({4'd0, cur.t})
       - $signed({4'd0, cur.w2}) - $signed({3'd0, cur.w5, 1'b0}) - $signed({4'd0, cur.b});
    agx = gx[11] ? 11'(-gx) : 11'(gx);
    agy = gy[11] ? 11'(-gy) : 11'(gy);
    // two radicand bits per step, one root bit out
    rem_sh = {rem[15:0], sum[17:16]};
    trial = {1'b0, rem_sh} - {8'd0, root, 2'b01};
    root_next = {root[7:0], !trial[18]};
  end

  logic cur_last;
  always_comb begin
    out_data.edge_value = cur.w4;
    out_data.on_border = 1'b1;
    out_data.frame_end = 1'b0;
    out_data.out_row = cur.r - 8'd1;
    out_data.out_col = cur.c - 8'd1;
    cur_last = 1'b0;
    if (pend[0]) begin
      if (!cur.mid_border) begin
        out_data.edge_value = mag;
        out_data.on_border = 1'b0;
      end
      cur_last = (pend[3:1] == 3'b000);
    end else if (pend[1]) begin
      out_data.out_col = cur.c;
      out_data.edge_value = cur.m;
      cur_last = (pend[3:2] == 2'b00);
    end else if (pend[2]) begin
      out_data.out_row = cur.r;
      out_data.edge_value = cur.w5;
      cur_last = !pend[3];
    end else begin
      out_data.out_row = cur.r;
      out_data.out_col = cur.c;
      out_data.edge_value = cur.b;
      out_data.frame_end = 1'b1;
      cur_last = 1'b1;
    end
    out_data.run_last = cur_last;
  end

  assign job_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur <= job;
            pend <= {job.e_corner, job.e_bot, job.e_right, job.e_mid};
            if (job.e_mid && !job.mid_border) state <= ST_GRAD;
            else if (job.e_mid || job.e_right || job.e_bot || job.e_corner) state <= ST_EMIT;
          end
        end
        ST_GRAD: begin
          ax <= (agx > 11'd255) ? 8'd255 : agx[7:0];
          ay <= (agy > 11'd255) ? 8'd255 : agy[7:0];
          state <= ST_SQ;
        end
        ST_SQ: begin
          sum <= 18'(ax * ax) + 18'(ay * ay);
          rem <= '0;
          root <= '0;
          step <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          sum <= {sum[15:0], 2'b00};
          if (!trial[18]) rem <= trial[16:0];
          else rem <= rem_sh[16:0];
          root <= root_next;
          step <= step + 4'd1;
          if (step == 4'd8) begin
            // root can reach 360, clamp to 8 bits
            mag <= root_next[8] ? 8'd255 : root_next[7:0];
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (pend[0]) pend[0] <= 1'b0;
            else if (pend[1]) pend[1] <= 1'b0;
            else if (pend[2]) pend[2] <= 1'b0;
            else pend[3] <= 1'b0;
            if (cur_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### rtl/sobel_edge_magnitude.sv
// 3x3 sobel gradient magnitude over a raster pixel stream. the front end takes no new pixel
// while the previous one is still in stage 1: it reads the two line stores one pixel at a
// time and hands a complete neighborhood to the back end through a one-entry queue. the
// back end takes a pixel with an interior result through gradient, square, then a 9-step
// digit-by-digit square root before it emits its results, and emits them straight away
// otherwise. the result for (r, c) appears while pixel (r+1, c+1) is processed, or the
// nearest one that exists in the last row or column; border pixels pass through.
// frame_width and frame_height are clamped to [3, MAX] and may only change while idle.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [8:0]         cfg_data,
  input  sem_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output sem_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  sem_pkg::job_t job;
  logic job_valid, job_ready;

  sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .in_data, .in_valid, .in_ready,
    .job, .job_valid, .job_ready
  );

  sem_back u_back (
    .clk, .rst, .job, .job_valid, .job_ready, .out_data, .out_valid, .out_ready
  );
endmodule

### rtl/sem_checker.sv
module sem_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input sem_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_border_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.on_border && out_data.run_last)
    else $error("frame end not a border last result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

  // more results of the same pixel follow without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.run_last |=> out_valid)
    else $error("run ended before its last result");
endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk, .rst, .in_valid, .in_ready, .out_data, .out_valid, .out_ready
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  localparam int MaxW = 256;
  localparam int MaxH = 256;
  localparam int StallLimit = 20000;

  // expected results and the software copy of the filter state
  class edge_scoreboard;
    sem_pkg::out_item_t pending[$];
    int unsigned width_reg;
    int unsigned height_reg;
    logic [7:0] upper[MaxW];
    logic [7:0] middle[MaxW];
    logic [7:0] win[6];
    int unsigned row;
    int unsigned col;
    int errors;

    function void clear();
      width_reg = 188;
      height_reg = 120;
      foreach (upper[i]) begin
        upper[i] = 8'd0;
        middle[i] = 8'd0;
      end
      foreach (win[i]) win[i] = 8'd0;
      row = 0;
      col = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [8:0] v);
      if (idx == sem_pkg::CfgIdxWidth) width_reg = {23'd0, v};
      else height_reg = {23'd0, v};
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned sat_abs(int g);
      int unsigned a;
      a = (g < 0) ? -g : g;
      return (a > 255) ? 255 : a;
    endfunction

    function int unsigned floor_root(int unsigned v);
      int unsigned x;
      x = 0;
      while ((x + 1) * (x + 1) <= v) x++;
      return x;
    endfunction

    function void push(int unsigned r, int unsigned c, int unsigned v, bit bord, bit fend);
      sem_pkg::out_item_t o;
      o.out_row = r[7:0];
      o.out_col = c[7:0];
      o.edge_value = v[7:0];
      o.on_border = bord;
      o.frame_end = fend;
      o.run_last = 1'b0;
      pending.push_back(o);
    endfunction

    function void note_pixel(sem_pkg::in_item_t it);
      int unsigned w, h, r, c, t, m, b, mag, n0;
      int gx, gy;
      w = clip(width_reg, MaxW);
      h = clip(height_reg, MaxH);
      n0 = pending.size();
      if (it.frame_start) begin
        row = 0;
        col = 0;
      end
      if (col >= w) col = w - 1;
      if (row >= h) row = h - 1;
      r = row;
      c = col;
      t = upper[c];
      m = middle[c];
      b = it.pixel;
      if (r >= 1 && c >= 1) begin
        if (r == 1 || c == 1) begin
          push(r - 1, c - 1, win[4], 1, 0);
        end else begin
          gx = (t + 2 * m + b) - (win[0] + 2 * win[1] + win[2]);
          gy = (win[0] + 2 * win[3] + t) - (win[2] + 2 * win[5] + b);
          mag = floor_root(sat_abs(gx) ** 2 + sat_abs(gy) ** 2);
          if (mag > 255) mag = 255;
          push(r - 1, c - 1, mag, 0, 0);
        end
        if (c == w - 1) push(r - 1, c, m, 1, 0);
      end
      if (r == h - 1 && c >= 1) begin
        push(r, c - 1, win[5], 1, 0);
        if (c == w - 1) push(r, c, b, 1, 1);
      end
      if (pending.size() > n0) pending[pending.size() - 1].run_last = 1'b1;
      upper[c] = 8'(m);
      middle[c] = 8'(b);
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = 8'(t);
      win[4] = 8'(m);
      win[5] = 8'(b);
      if (c >= w - 1) begin
        col = 0;
        row = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    task check_result(sem_pkg::out_item_t got);
      sem_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("unexpected transaction %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
      if (got.out_col !== want.out_col) report("out_col", got.out_col, want.out_col);
      if (got.edge_value !== want.edge_value)
        report("edge_value", got.edge_value, want.edge_value);
      if (got.on_border !== want.on_border)
        report("on_border", {7'd0, got.on_border}, {7'd0, want.on_border});
      if (got.frame_end !== want.frame_end)
        report("frame_end", {7'd0, got.frame_end}, {7'd0, want.frame_end});
      if (got.run_last !== want.run_last)
        report("run_last", {7'd0, got.run_last}, {7'd0, want.run_last});
    endtask

    task report(string f, logic [7:0] g, logic [7:0] w);
      $display("mismatch %s: got %0d want %0d at %0t", f, g, w, $realtime);
      errors++;
    endtask
  endclass

  logic clk, rst;
  logic cfg_we, cfg_idx;
  logic [8:0] cfg_data;
  sem_pkg::in_item_t in_data;
  logic in_valid, in_ready;
  sem_pkg::out_item_t out_data;
  logic out_valid, out_ready;

  edge_scoreboard sb;
  int idle_cycles;
  int hold_req;
  int hold_served;
  int mode;

  sobel_edge_magnitude dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic write_reg(int idx, logic [8:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx[0];
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // one pixel transaction with a random lead-in gap; valid stays up when there is no gap
  task automatic send_pixel(logic [7:0] p, bit fs);
    int gap;
    gap = (mode == 1) ? 0 : $urandom_range(0, 12);
    if (mode == 2 && $urandom_range(0, 3) != 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{pixel: p, frame_start: fs};
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(in_data);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_frame(int w, int h, int kind);
    logic [7:0] p;
    for (int i = 0; i < w * h; i++) begin
      case (kind)
        0: p = 8'($urandom_range(0, 255));
        1: p = ((i % w) < w / 2) ? 8'd0 : 8'd255;
        2: p = ((i / w) % 2) ? 8'd255 : 8'd0;
        default: p = ((i % 2) ^ ((i / w) % 2)) ? 8'd255 : 8'd0;
      endcase
      send_pixel(p, i == 0);
    end
  endtask

  // receiver with random stalls and one long hold-off on request
  initial begin
    int gap;
    out_ready <= 0;
    @(negedge rst);
    forever begin
      if (hold_served != hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_served = hold_req;
      end
      gap = (mode == 1) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (hold_req != hold_served))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("sobel_edge_magnitude regression: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    rst <= 1;
    cfg_we <= 0;
    cfg_idx <= 0;
    cfg_data <= 0;
    in_valid <= 0;
    in_data <= '0;
    mode = 0;
    hold_req = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: smallest frame, extremes, edges, register clamping
    write_reg(sem_pkg::CfgIdxWidth, 9'd3);
    write_reg(sem_pkg::CfgIdxHeight, 9'd3);
    send_frame(3, 3, 1);
    send_frame(3, 3, 3);
    drain();
    write_reg(sem_pkg::CfgIdxWidth, 9'd0);
    write_reg(sem_pkg::CfgIdxHeight, 9'h1ff);
    drain();
    write_reg(sem_pkg::CfgIdxHeight, 9'd1);
    send_frame(3, 3, 2);
    drain();

    // random frames, small sizes
    for (int f = 0; f < 6; f++) begin
      int w, h;
      w = $urandom_range(3, 7);
      h = $urandom_range(3, 6);
      mode = $urandom_range(0, 2);
      write_reg(sem_pkg::CfgIdxWidth, 9'(w));
      write_reg(sem_pkg::CfgIdxHeight, 9'(h));
      if (f == 4) hold_req = hold_req + 1;
      send_frame(w, h, $urandom_range(0, 3));
      // noise: restart mid-frame, then a full frame to resync
      if (f % 4 == 3) begin
        repeat ($urandom_range(1, 5)) send_pixel(8'($urandom), 0);
        send_frame(w, h, 0);
      end
      drain();
    end

    // wide rows, three rows, no idle gaps
    mode = 1;
    write_reg(sem_pkg::CfgIdxWidth, 9'd40);
    write_reg(sem_pkg::CfgIdxHeight, 9'd3);
    send_frame(40, 3, 0);
    mode = 0;
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sobel_edge_magnitude regression: pass");
    else
      $display("sobel_edge_magnitude regression: fail");
    $finish;
  end
endmodule
